// File: src/atl_pkg.sv
// Shared types, constants and helper functions for the assembly token lexer.
// No dependencies; every other file of the block but atl_byte_if imports this package.
package atl_pkg;

    // Longest word before it is closed, and the width of its length counter
    localparam int MAX_WORD = 64;
    localparam int WLEN_W   = $clog2(MAX_WORD + 1);

    // Result queue geometry
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam int NUM_MNEM = 10;
    localparam int NUM_REGS = 4;

    typedef enum logic [3:0] {
        K_EOF      = 4'd0,
        K_MNEM     = 4'd1,
        K_NEWLINE  = 4'd2,
        K_NUMBER   = 4'd3,
        K_COMMA    = 4'd4,
        K_REG      = 4'd5,
        K_UNKNOWN  = 4'd6,
        K_OTHER    = 4'd7,
        K_BADDIGIT = 4'd8,
        K_OVERFLOW = 4'd9
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] value;
    } t_tok;

    // Up to two tokens per source byte, first one in tok0
    typedef struct packed {
        logic [1:0] cnt;
        t_tok       tok0;
        t_tok       tok1;
    } t_push;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_BEL   = 8'h07;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    // Names packed first character high, as the word prefix register holds them
    localparam logic [31:0] MNEM_NAMES [NUM_MNEM] = '{
        32'h006D6F76, // mov
        32'h00616464, // add
        32'h00696E63, // inc
        32'h00737562, // sub
        32'h00646563, // dec
        32'h006D756C, // mul
        32'h00646976, // div
        32'h70757368, // push
        32'h00706F70, // pop
        32'h006F7574  // out
    };

    localparam logic [31:0] REG_NAMES [NUM_REGS] = '{
        32'h00656178, // eax
        32'h00656278, // ebx
        32'h00656378, // ecx
        32'h00656478  // edx
    };

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_hex_letter(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_TAB) || (c == CH_SPACE) || (c == CH_CR) ||
               (c == CH_VT) || (c == CH_BS) || (c == CH_BEL);
    endfunction

    // Classify a finished word; names are unique, so compare order is free
    function automatic t_tok word_tok(input logic [31:0] pre, input logic [WLEN_W-1:0] len);
        t_tok t;
        t.kind  = K_UNKNOWN;
        t.value = '0;
        if (len <= WLEN_W'(4)) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                if (pre == REG_NAMES[i]) begin
                    t.kind  = K_REG;
                    t.value = 32'(i + 1);
                end
            end
            for (int i = 0; i < NUM_MNEM; i++) begin
                if (pre == MNEM_NAMES[i]) begin
                    t.kind  = K_MNEM;
                    t.value = 32'(i + 1);
                end
            end
        end
        return t;
    endfunction

endpackage

// File: src/atl_byte_if.sv
// Source byte channel of the assembly token lexer.
// Does not depend on atl_pkg; carries valid, ready and one byte.
interface atl_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink   (input valid, input ch, output ready);
endinterface

// File: src/atl_tok_if.sv
// Token channel of the assembly token lexer.
// Depends on atl_pkg for the token kind type.
interface atl_tok_if
    import atl_pkg::*;
;
    logic        valid;
    logic        ready;
    t_kind       token_kind;
    logic [31:0] token_value;

    modport source (output valid, output token_kind, output token_value, input ready);
    modport sink   (input valid, input token_kind, input token_value, output ready);
endinterface

// File: src/atl_core.sv
// Lexer core: scan state and the per-byte token decision.
// Depends on atl_pkg; feeds up to two tokens per byte to atl_tok_fifo.
module atl_core
    import atl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_vld,
    input  logic [7:0] i_ch,
    output t_push      o_push
);

    typedef enum logic [4:0] {
        M_IDLE = 5'b00001,
        M_NUM  = 5'b00010,
        M_SKIP = 5'b00100,
        M_WORD = 5'b01000,
        M_CMT  = 5'b10000
    } t_mode;

    // Outcome of a byte seen with no token pending
    typedef struct packed {
        t_mode              mode;
        logic [63:0]        acc;
        logic [31:0]        pre;
        logic [WLEN_W-1:0]  len;
        logic               emit;
        t_tok               tok;
    } t_idle;

    t_mode             r_mode, n_mode;
    logic [63:0]       r_acc,  n_acc;
    logic [31:0]       r_pre,  n_pre;
    logic [WLEN_W-1:0] r_len,  n_len;

    logic        a_vld, b_vld;
    t_tok        a_tok, b_tok;
    t_idle       idl;
    logic [67:0] num_sum;
    logic [31:0] add_pre;
    logic [WLEN_W-1:0] add_len;

    function automatic t_idle idle_byte(input logic [7:0] c);
        t_idle r;
        r.mode      = M_IDLE;
        r.acc       = '0;
        r.pre       = '0;
        r.len       = '0;
        r.emit      = 1'b0;
        r.tok.kind  = K_OTHER;
        r.tok.value = 32'(c);
        if (is_digit(c)) begin
            r.mode = M_NUM;
            r.acc  = 64'(c - CH_ZERO);
        end else if (is_letter(c)) begin
            r.mode = M_WORD;
            r.pre  = 32'(c);
            r.len  = WLEN_W'(1);
        end else if (c == CH_NL) begin
            r.emit = 1'b1;
            r.tok  = '{kind: K_NEWLINE, value: '0};
        end else if (is_blank(c)) begin
            r.emit = 1'b0;
        end else if (c == CH_COMMA) begin
            r.emit = 1'b1;
            r.tok  = '{kind: K_COMMA, value: '0};
        end else if (c == CH_SEMI) begin
            r.mode = M_CMT;
        end else if (c == CH_NUL) begin
            r.emit = 1'b1;
            r.tok  = '{kind: K_EOF, value: '0};
        end else begin
            r.emit = 1'b1;
        end
        return r;
    endfunction

    assign idl     = idle_byte(i_ch);
    // acc * 10 + digit; anything above bit 63 is an overflow
    assign num_sum = 68'({r_acc, 3'b000}) + 68'({r_acc, 1'b0}) + 68'(i_ch - CH_ZERO);
    assign add_pre = (r_len < WLEN_W'(4)) ? {r_pre[23:0], i_ch} : 32'hFFFF_FFFF;
    assign add_len = r_len + WLEN_W'(1);

    always_comb begin
        n_mode = r_mode;
        n_acc  = r_acc;
        n_pre  = r_pre;
        n_len  = r_len;
        a_vld  = 1'b0;
        a_tok  = '{kind: K_EOF, value: '0};
        b_vld  = 1'b0;
        b_tok  = idl.tok;
        unique case (r_mode)
            M_NUM: begin
                if (is_digit(i_ch)) begin
                    if (num_sum[67:64] != 4'd0) begin
                        a_vld  = 1'b1;
                        a_tok  = '{kind: K_OVERFLOW, value: '0};
                        n_acc  = '0;
                        n_mode = M_SKIP;
                    end else begin
                        n_acc = num_sum[63:0];
                    end
                end else if (is_hex_letter(i_ch)) begin
                    a_vld  = 1'b1;
                    a_tok  = '{kind: K_BADDIGIT, value: 32'(i_ch)};
                    n_acc  = '0;
                    n_mode = M_IDLE;
                end else begin
                    a_vld  = 1'b1;
                    a_tok  = '{kind: K_NUMBER, value: r_acc[31:0]};
                    n_mode = idl.mode;
                    n_acc  = idl.acc;
                    n_pre  = idl.pre;
                    n_len  = idl.len;
                    b_vld  = idl.emit;
                end
            end
            M_SKIP: begin
                if (!is_digit(i_ch)) begin
                    n_mode = idl.mode;
                    n_acc  = idl.acc;
                    n_pre  = idl.pre;
                    n_len  = idl.len;
                    b_vld  = idl.emit;
                end
            end
            M_WORD: begin
                if (is_letter(i_ch) || is_digit(i_ch)) begin
                    if (add_len >= WLEN_W'(MAX_WORD)) begin
                        // Close a word that reached its length limit
                        a_vld  = 1'b1;
                        a_tok  = word_tok(add_pre, add_len);
                        n_mode = M_IDLE;
                        n_pre  = '0;
                        n_len  = '0;
                    end else begin
                        n_pre = add_pre;
                        n_len = add_len;
                    end
                end else begin
                    a_vld  = 1'b1;
                    a_tok  = word_tok(r_pre, r_len);
                    n_mode = idl.mode;
                    n_acc  = idl.acc;
                    n_pre  = idl.pre;
                    n_len  = idl.len;
                    b_vld  = idl.emit;
                end
            end
            M_CMT: begin
                if (i_ch == CH_NL) begin
                    a_vld  = 1'b1;
                    a_tok  = '{kind: K_NEWLINE, value: '0};
                    n_mode = M_IDLE;
                end else if (i_ch == CH_NUL) begin
                    a_vld  = 1'b1;
                    a_tok  = '{kind: K_EOF, value: '0};
                    n_mode = M_IDLE;
                end
            end
            default: begin
                n_mode = idl.mode;
                n_acc  = idl.acc;
                n_pre  = idl.pre;
                n_len  = idl.len;
                b_vld  = idl.emit;
            end
        endcase
    end

    // Pack the tokens so that the first one emitted sits in tok0
    always_comb begin
        o_push.tok0 = a_vld ? a_tok : b_tok;
        o_push.tok1 = b_tok;
        if (!i_vld) begin
            o_push.cnt = 2'd0;
        end else begin
            o_push.cnt = 2'(a_vld) + 2'(b_vld);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_acc  <= '0;
            r_pre  <= '0;
            r_len  <= '0;
        end else if (i_vld) begin
            r_mode <= n_mode;
            r_acc  <= n_acc;
            r_pre  <= n_pre;
            r_len  <= n_len;
        end
    end

`ifndef SYNTHESIS
    a_word_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == M_WORD) |-> (r_len != '0) && (r_len < WLEN_W'(MAX_WORD)))
        else $error("word length out of range while scanning a word");

    a_acc_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode != M_NUM) |-> (r_acc == '0))
        else $error("number accumulator not cleared outside a number");

    a_word_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode != M_WORD) |-> (r_len == '0) && (r_pre == '0))
        else $error("word state not cleared outside a word");
`endif

endmodule

// File: src/atl_tok_fifo.sv
// Result queue: takes up to two tokens a cycle and drives the token channel.
// Depends on atl_pkg and atl_tok_if.
module atl_tok_fifo
    import atl_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_push            i_push,
    output logic             o_space,
    atl_tok_if.source        o_tok
);

    t_tok              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr, n_wr;
    logic [QPTR_W-1:0] r_rd, n_rd;
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    logic              pop;

    assign pop               = o_tok.valid && o_tok.ready;
    assign o_tok.valid       = (r_cnt != '0);
    assign o_tok.token_kind  = r_mem[r_rd].kind;
    assign o_tok.token_value = r_mem[r_rd].value;
    // Room for a full pair of tokens
    assign o_space           = (r_cnt <= QCNT_W'(QDEPTH - 2));

    assign n_wr  = r_wr + QPTR_W'(i_push.cnt);
    assign n_rd  = r_rd + QPTR_W'(pop);
    assign n_cnt = r_cnt + QCNT_W'(i_push.cnt) - QCNT_W'(pop);

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr] <= i_push.tok0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[r_wr + QPTR_W'(1)] <= i_push.tok1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCNT_W'(QDEPTH))
        else $error("token queue count above depth");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.cnt != 2'd0) |-> (r_cnt <= QCNT_W'(QDEPTH - 2)))
        else $error("tokens pushed without room for a pair");
`endif

endmodule

// File: src/asm_token_lexer_unit.sv
// Top level of the assembly token lexer: input register, lexer core, token queue.
// Depends on atl_pkg, atl_byte_if, atl_tok_if, atl_core and atl_tok_fifo.
//
//  channel   dir  payload                              handshake
//  i_byte    in   ch[7:0], 0 = end of input            valid / ready
//  o_tok     out  token_kind[3:0], token_value[31:0]   valid / ready
//
// One source byte is taken per cycle while i_byte.ready is high. A byte is held
// in the input register, is decided by the core and lands in the token queue,
// from which its first token is presented on o_tok.
// A byte yields zero, one or two tokens; the token port moves one a cycle
// when ready, so a stream averaging more tokens than bytes runs at the token rate.
// i_byte.ready falls only while the queue lacks room for two more tokens.
// Synchronous active-low reset clears the scan state and empties the queue.
module asm_token_lexer_unit
    import atl_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    atl_byte_if.sink  i_byte,
    atl_tok_if.source o_tok
);

    logic       r_vld;
    logic [7:0] r_ch;
    logic       advance;
    logic       space;
    t_push      push;

    // Hand the held byte to the core when the queue can absorb a pair
    assign advance      = r_vld && space;
    assign i_byte.ready = !r_vld || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_byte.valid && i_byte.ready) begin
            r_vld <= 1'b1;
        end else if (advance) begin
            r_vld <= 1'b0;
        end
    end

    // Payload register: load on every accepted item
    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_ch <= i_byte.ch;
        end
    end

    atl_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (advance),
        .i_ch    (r_ch),
        .o_push  (push)
    );

    atl_tok_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_space (space),
        .o_tok   (o_tok)
    );

endmodule

// File: sim/atl_token_checker.sv
`timescale 1ns / 100ps
// Token checker for the assembly token lexer: predicts the tokens of every accepted
// source byte and compares them with the tokens leaving the block.
// Depends on atl_pkg, atl_byte_if and atl_tok_if.
module atl_token_checker
    import atl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    atl_byte_if        i_byte,
    atl_tok_if         i_tok,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_bytes_seen,
    output int         o_toks_seen,
    output logic [9:0] o_kinds_seen
);

    localparam int MAX_REPORTS = 50;

    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_NUMBER,
        SCAN_SKIP,
        SCAN_WORD,
        SCAN_COMMENT
    } t_scan;

    t_scan       scan;
    logic [63:0] num_acc;
    logic [31:0] word_pre;
    logic [7:0]  word_len;
    t_tok        expected_toks [$];
    int          reports;

    function automatic logic digit_byte(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic letter_byte(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    task automatic queue_tok(input t_kind k, input logic [31:0] v);
        t_tok t;
        t.kind  = k;
        t.value = v;
        expected_toks.push_back(t);
    endtask

    // Classify the pending word by its packed prefix, case-sensitive
    task automatic close_word();
        t_kind       k;
        logic [31:0] v;
        k = K_UNKNOWN;
        v = '0;
        if (word_len <= 8'd4) begin
            case (word_pre)
                "mov":  begin k = K_MNEM; v = 32'd1;  end
                "add":  begin k = K_MNEM; v = 32'd2;  end
                "inc":  begin k = K_MNEM; v = 32'd3;  end
                "sub":  begin k = K_MNEM; v = 32'd4;  end
                "dec":  begin k = K_MNEM; v = 32'd5;  end
                "mul":  begin k = K_MNEM; v = 32'd6;  end
                "div":  begin k = K_MNEM; v = 32'd7;  end
                "push": begin k = K_MNEM; v = 32'd8;  end
                "pop":  begin k = K_MNEM; v = 32'd9;  end
                "out":  begin k = K_MNEM; v = 32'd10; end
                "eax":  begin k = K_REG;  v = 32'd1;  end
                "ebx":  begin k = K_REG;  v = 32'd2;  end
                "ecx":  begin k = K_REG;  v = 32'd3;  end
                "edx":  begin k = K_REG;  v = 32'd4;  end
                default: ;
            endcase
        end
        queue_tok(k, v);
        word_pre = '0;
        word_len = '0;
    endtask

    task automatic add_word_char(input logic [7:0] c);
        if (word_len < 8'd4) word_pre = {word_pre[23:0], c};
        else word_pre = '1;
        word_len = word_len + 8'd1;
        if (word_len >= MAX_WORD) begin
            close_word();
            scan = SCAN_IDLE;
        end
    endtask

    task automatic scan_idle(input logic [7:0] c);
        scan = SCAN_IDLE;
        if (digit_byte(c)) begin
            scan    = SCAN_NUMBER;
            num_acc = 64'(c) - 64'h30;
        end else if (letter_byte(c)) begin
            scan     = SCAN_WORD;
            word_pre = '0;
            word_len = '0;
            add_word_char(c);
        end else if (c == CH_NL) begin
            queue_tok(K_NEWLINE, '0);
        end else if (c == CH_TAB || c == CH_SPACE || c == CH_CR ||
                     c == CH_VT || c == CH_BS || c == CH_BEL) begin
            // blank
        end else if (c == CH_COMMA) begin
            queue_tok(K_COMMA, '0);
        end else if (c == CH_SEMI) begin
            scan = SCAN_COMMENT;
        end else if (c == CH_NUL) begin
            queue_tok(K_EOF, '0);
        end else begin
            queue_tok(K_OTHER, {24'h0, c});
        end
    endtask

    task automatic predict_tokens(input logic [7:0] c);
        logic [63:0] d;
        d = 64'(c) - 64'h30;
        case (scan)
            SCAN_NUMBER: begin
                if (digit_byte(c)) begin
                    if (num_acc > (64'hFFFF_FFFF_FFFF_FFFF - d) / 64'd10) begin
                        queue_tok(K_OVERFLOW, '0);
                        num_acc = '0;
                        scan    = SCAN_SKIP;
                    end else begin
                        num_acc = num_acc * 64'd10 + d;
                    end
                end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
                    queue_tok(K_BADDIGIT, {24'h0, c});
                    num_acc = '0;
                    scan    = SCAN_IDLE;
                end else begin
                    queue_tok(K_NUMBER, num_acc[31:0]);
                    num_acc = '0;
                    scan_idle(c);
                end
            end
            SCAN_SKIP: begin
                if (!digit_byte(c)) scan_idle(c);
            end
            SCAN_WORD: begin
                if (letter_byte(c) || digit_byte(c)) begin
                    add_word_char(c);
                end else begin
                    close_word();
                    scan_idle(c);
                end
            end
            SCAN_COMMENT: begin
                if (c == CH_NL) begin
                    queue_tok(K_NEWLINE, '0);
                    scan = SCAN_IDLE;
                end else if (c == CH_NUL) begin
                    queue_tok(K_EOF, '0);
                    scan = SCAN_IDLE;
                end
            end
            default: scan_idle(c);
        endcase
    endtask

    always @(posedge i_clk) begin
        t_tok exp_tok;
        logic bad;
        if (!i_rst_n) begin
            scan     = SCAN_IDLE;
            num_acc  = '0;
            word_pre = '0;
            word_len = '0;
            expected_toks.delete();
            reports      = 0;
            o_fail_count = 0;
            o_bytes_seen = 0;
            o_toks_seen  = 0;
            o_kinds_seen = '0;
        end else begin
            // Compare first: a token leaving now never stems from a byte taken now
            if (i_tok.valid && i_tok.ready) begin
                o_toks_seen++;
                if (i_tok.token_kind <= K_OVERFLOW) o_kinds_seen[i_tok.token_kind] = 1'b1;
                if (expected_toks.size() == 0) begin
                    o_fail_count++;
                    if (reports < MAX_REPORTS)
                        $display("%0t: unexpected token: expected none, actual kind %0d value %h",
                                 $time, i_tok.token_kind, i_tok.token_value);
                    reports++;
                end else begin
                    exp_tok = expected_toks.pop_front();
                    bad = 1'b0;
                    if (i_tok.token_kind !== exp_tok.kind) begin
                        bad = 1'b1;
                        if (reports < MAX_REPORTS)
                            $display("%0t: token %0d kind: expected %0d actual %0d",
                                     $time, o_toks_seen, exp_tok.kind, i_tok.token_kind);
                    end
                    if (i_tok.token_value !== exp_tok.value) begin
                        bad = 1'b1;
                        if (reports < MAX_REPORTS)
                            $display("%0t: token %0d value: expected %h actual %h",
                                     $time, o_toks_seen, exp_tok.value, i_tok.token_value);
                    end
                    if (bad) begin
                        o_fail_count++;
                        reports++;
                    end
                end
            end
            if (i_byte.valid && i_byte.ready) begin
                o_bytes_seen++;
                predict_tokens(i_byte.ch);
            end
        end
        o_pending = expected_toks.size();
    end

endmodule

// File: sim/asm_token_lexer_unit_tb.sv
`timescale 1ns / 100ps
// Testbench top for the assembly token lexer: builds assembly-like source text,
// feeds it in bursts and stalls the token side; atl_token_checker does the scoring.
// Depends on atl_pkg, atl_byte_if, atl_tok_if, atl_token_checker and the block.
module asm_token_lexer_unit_tb;
    import atl_pkg::*;

    localparam int SOURCE_LEN   = 1650;   // rough size of the random text
    localparam int LONG_HOLD_AT = 700;    // bytes sent before the long receiver hold
    localparam int LONG_HOLD    = 300;    // cycles the receiver holds off
    localparam int PAUSE_AT     = 1200;   // byte index where the sender waits for a drain
    localparam int DRAIN_LIMIT  = 20000;  // cycles allowed for the final drain
    localparam int TAIL_CYCLES  = 16;     // margin after the drain for tokens still in the block

    // Receiver stall patterns
    typedef enum int {
        RX_FREE,     // always ready
        RX_COIN,     // ready half the time
        RX_MOSTLY,   // ready with a chance of nine in ten
        RX_SPARSE    // ready with a chance of one in four
    } t_rx_mode;

    logic i_clk;
    logic i_rst_n;

    atl_byte_if byte_if ();
    atl_tok_if  tok_if ();

    int         fail_count;
    int         pending;
    int         bytes_seen;
    int         toks_seen;
    logic [9:0] kinds_seen;

    logic [7:0] src_bytes [$];
    int         sent_count;
    bit         long_hold_done;

    string MNEM_TEXT [10] = '{"mov", "add", "inc", "sub", "dec",
                              "mul", "div", "push", "pop", "out"};
    string REG_TEXT  [4]  = '{"eax", "ebx", "ecx", "edx"};

    asm_token_lexer_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_if),
        .o_tok   (tok_if)
    );

    // Scoreboard sits beside the block and only watches both channels
    atl_token_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte       (byte_if),
        .i_tok        (tok_if),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_bytes_seen (bytes_seen),
        .o_toks_seen  (toks_seen),
        .o_kinds_seen (kinds_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs a handshake
    initial begin
        #3_000_000;
        $display("Timeout: token stream did not drain");
        $display("RESULT: ERROR");
        $finish;
    end

    // ---------------------------------------------------------------
    // Source text generation
    // ---------------------------------------------------------------

    function automatic void push_text(input string s);
        for (int j = 0; j < s.len(); j++) src_bytes.push_back(s[j]);
    endfunction

    function automatic logic [7:0] rand_letter();
        if ($urandom_range(0, 3) == 0) return 8'h41 + 8'($urandom_range(0, 25));
        return 8'h61 + 8'($urandom_range(0, 25));
    endfunction

    // Letters and digits, as they may continue a word
    function automatic void push_word_tail(input int n);
        for (int j = 0; j < n; j++) begin
            if ($urandom_range(0, 3) == 0) src_bytes.push_back(8'h30 + 8'($urandom_range(0, 9)));
            else src_bytes.push_back(rand_letter());
        end
    endfunction

    function automatic void push_digits(input int n);
        for (int j = 0; j < n; j++) src_bytes.push_back(8'h30 + 8'($urandom_range(0, 9)));
    endfunction

    // Zero to two blanks, mostly spaces; force at least one where tokens would merge
    function automatic void push_blanks(input bit need_one);
        logic [7:0] blank_set [6];
        int         n;
        blank_set = '{CH_SPACE, CH_TAB, CH_CR, CH_VT, CH_BS, CH_BEL};
        n = $urandom_range(need_one ? 1 : 0, 2);
        for (int j = 0; j < n; j++) begin
            if ($urandom_range(0, 2) != 0) src_bytes.push_back(CH_SPACE);
            else src_bytes.push_back(blank_set[$urandom_range(0, 5)]);
        end
    endfunction

    function automatic void push_word();
        string s;
        int    pick;
        pick = $urandom_range(0, 19);
        if (pick < 8) begin
            push_text(REG_TEXT[$urandom_range(0, 3)]);
        end else if (pick < 10) begin
            push_text(MNEM_TEXT[$urandom_range(0, 9)]);
        end else if (pick < 12) begin
            // name plus a tail: no longer a name
            push_text($urandom_range(0, 1) ? REG_TEXT[$urandom_range(0, 3)]
                                           : MNEM_TEXT[$urandom_range(0, 9)]);
            push_word_tail($urandom_range(1, 3));
        end else if (pick < 13) begin
            // upper-case spelling does not match
            s = $urandom_range(0, 1) ? REG_TEXT[$urandom_range(0, 3)]
                                     : MNEM_TEXT[$urandom_range(0, 9)];
            for (int j = 0; j < s.len(); j++) src_bytes.push_back(s[j] - 8'h20);
        end else if (pick < 14) begin
            // around the word length limit, so a word may close by itself
            src_bytes.push_back(rand_letter());
            push_word_tail(MAX_WORD - 3 + $urandom_range(0, 4));
        end else begin
            src_bytes.push_back(rand_letter());
            push_word_tail($urandom_range(0, 5));
        end
    endfunction

    function automatic void push_number();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 9) begin
            push_digits($urandom_range(1, 3));
        end else if (pick < 13) begin
            push_digits($urandom_range(4, 10));
        end else if (pick < 15) begin
            push_digits($urandom_range(17, 22));
        end else if (pick == 15) begin
            push_text("18446744073709551615");
        end else if (pick == 16) begin
            push_text("18446744073709551616");
        end else if (pick == 17) begin
            push_text("99999999999999999999123");
        end else begin
            // digits then a hex letter
            push_digits($urandom_range(1, 4));
            if ($urandom_range(0, 1)) src_bytes.push_back(8'h61 + 8'($urandom_range(0, 5)));
            else src_bytes.push_back(8'h41 + 8'($urandom_range(0, 5)));
        end
    endfunction

    // Comment body: anything but newline and end of input
    function automatic void push_comment_body();
        logic [7:0] c;
        int         n;
        n = $urandom_range(0, 12);
        for (int j = 0; j < n; j++) begin
            c = 8'($urandom_range(1, 255));
            if (c == CH_NL) c = CH_SPACE;
            src_bytes.push_back(c);
        end
    endfunction

    function automatic void push_line();
        int pick;
        int ops;
        int ending;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            // raw noise: every byte value, end of input included
            for (int j = $urandom_range(1, 6); j > 0; j--)
                src_bytes.push_back(8'($urandom_range(0, 255)));
        end else if (pick < 12) begin
            push_blanks(1'b0);
            src_bytes.push_back(CH_SEMI);
            push_comment_body();
            src_bytes.push_back(CH_NL);
        end else if (pick < 15) begin
            src_bytes.push_back(CH_NUL);
        end else begin
            push_blanks(1'b0);
            push_text(MNEM_TEXT[$urandom_range(0, 9)]);
            ops = $urandom_range(0, 3);
            for (int j = 0; j < ops; j++) begin
                if (j > 0) begin
                    push_blanks(1'b0);
                    src_bytes.push_back(CH_COMMA);
                    push_blanks(1'b0);
                end else begin
                    push_blanks(1'b1);
                end
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: push_word();
                    4, 5, 6, 7, 8: push_number();
                    default: begin
                        if ($urandom_range(0, 1)) push_text("[+-]");
                        else src_bytes.push_back(8'($urandom_range(128, 255)));
                    end
                endcase
            end
            ending = $urandom_range(0, 19);
            if (ending < 13) begin
                src_bytes.push_back(CH_NL);
            end else if (ending < 15) begin
                push_text("\r\n");
            end else if (ending < 17) begin
                push_blanks(1'b0);
                src_bytes.push_back(CH_SEMI);
                push_comment_body();
                src_bytes.push_back($urandom_range(0, 3) == 0 ? CH_NUL : CH_NL);
            end else if (ending < 19) begin
                src_bytes.push_back(CH_NUL);
            end
            // else: no terminator, the next line runs straight on
        end
    endfunction

    // ---------------------------------------------------------------
    // Sender: reset, directed text, then random lines in bursts
    // ---------------------------------------------------------------
    initial begin
        int idx;
        int burst;
        int gap;
        int k;
        int wait_cycles;

        i_rst_n       <= 1'b0;
        byte_if.valid <= 1'b0;
        byte_if.ch    <= 8'h00;
        sent_count     = 0;

        // Directed: names, bad digit, high byte, comment cut by end of input,
        // word cut by end of input, number closed by comma, bell blank, 0x80
        push_text("push edx,9F");
        src_bytes.push_back(8'hFF);
        src_bytes.push_back(CH_TAB);
        push_text(";x");
        src_bytes.push_back(CH_NUL);
        push_text("ok1");
        src_bytes.push_back(CH_NUL);
        src_bytes.push_back(CH_NL);
        push_text("7,");
        src_bytes.push_back(CH_BEL);
        src_bytes.push_back(8'h80);

        while (src_bytes.size() < SOURCE_LEN) push_line();
        src_bytes.push_back(CH_NUL);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idx = 0;
        while (idx < src_bytes.size()) begin
            burst = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
            for (k = 0; k < burst && idx < src_bytes.size(); k++) begin
                if (idx == PAUSE_AT) begin
                    // Hold off until every expected token has left the block
                    byte_if.valid <= 1'b0;
                    @(posedge i_clk);
                    @(posedge i_clk);
                    while (pending != 0) @(posedge i_clk);
                end
                byte_if.valid <= 1'b1;
                byte_if.ch    <= src_bytes[idx];
                @(posedge i_clk);
                while (!byte_if.ready) @(posedge i_clk);
                idx++;
                sent_count = idx;
            end
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                byte_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        byte_if.valid <= 1'b0;

        // Drain: wait out the expected tokens, then the pipeline latency
        @(posedge i_clk);
        wait_cycles = 0;
        while (pending != 0 && wait_cycles < DRAIN_LIMIT) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Summary: %0d source bytes, %0d tokens checked, token kinds seen %b",
                 bytes_seen, toks_seen, kinds_seen);
        $display("Summary: bursty input, patterned stalls, a %0d-cycle hold-off, a drain pause",
                 LONG_HOLD);
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            if (pending != 0) $display("%0t: %0d expected tokens never arrived", $time, pending);
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // ---------------------------------------------------------------
    // Receiver: switch between stall patterns, hold off once for long
    // ---------------------------------------------------------------
    initial begin
        t_rx_mode rx_mode;
        int       mode_left;

        tok_if.ready  <= 1'b0;
        long_hold_done = 1'b0;
        rx_mode        = RX_FREE;
        mode_left      = 0;
        forever begin
            @(posedge i_clk);
            if (!long_hold_done && sent_count >= LONG_HOLD_AT) begin
                // Stall long enough for the queue to fill and block the input
                long_hold_done = 1'b1;
                tok_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            if (mode_left == 0) begin
                case ($urandom_range(0, 3))
                    0: rx_mode = RX_FREE;
                    1: rx_mode = RX_COIN;
                    2: rx_mode = RX_MOSTLY;
                    default: rx_mode = RX_SPARSE;
                endcase
                mode_left = $urandom_range(32, 256);
            end
            mode_left--;
            case (rx_mode)
                RX_FREE:   tok_if.ready <= 1'b1;
                RX_COIN:   tok_if.ready <= 1'($urandom_range(0, 1));
                RX_MOSTLY: tok_if.ready <= ($urandom_range(0, 9) != 0);
                default:   tok_if.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

endmodule

// File: files.f
src/atl_pkg.sv
src/atl_byte_if.sv
src/atl_tok_if.sv
src/atl_core.sv
src/atl_tok_fifo.sv
src/asm_token_lexer_unit.sv
sim/atl_token_checker.sv
sim/asm_token_lexer_unit_tb.sv
